### design/dkpu_pkg.sv
// Shared types, widths and reset constants for the point update block.
`default_nettype none
package dkpu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned EST_W         = 32;
  localparam int unsigned VAR_W         = 31;
  localparam int unsigned IN_DATA_W     = 192;
  localparam int unsigned OUT_DATA_W    = 256;
  localparam int unsigned APB_ADDR_W    = 3;

  localparam logic [VAR_W-1:0] RESET_PIXEL_VAR = VAR_W'(65536);
  localparam logic [VAR_W-1:0] RESET_DEPTH_VAR = VAR_W'(655360);

  // Register indexes (paddr[2])
  localparam logic REG_PIXEL_VAR = 1'b0;
  localparam logic REG_DEPTH_VAR = 1'b1;

  // Command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_DIV,
    LANE_MUL,
    LANE_FIN
  } lane_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_RUN,
    TOP_FIN
  } top_state_e;

  // Operands handed to one component lane
  typedef struct packed {
    logic [VAR_W-1:0] var_s;
    logic [VAR_W-1:0] noise;
    logic [EST_W-1:0] meas;
    logic [EST_W-1:0] est;
  } lane_req_t;

  // Updated estimate and variance from one lane
  typedef struct packed {
    logic [EST_W-1:0] est;
    logic [VAR_W-1:0] var_s;
  } lane_res_t;

endpackage
`default_nettype wire

### design/dkpu_lane.sv
// One component lane: bit-serial gain divide, bit-serial gain multiply, final rounding.
`default_nettype none
module dkpu_lane import dkpu_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire lane_req_t req_i,
  output logic           done_o,
  output lane_res_t      res_o
);

  localparam int unsigned CntW  = $clog2(FracBits + 1);
  localparam int unsigned AccW  = 34 + FracBits;
  localparam int unsigned ProdW = VAR_W + FracBits;

  lane_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  logic            last_step;

  logic [EST_W-1:0]    den_q;
  logic [EST_W-1:0]    rem_q;
  logic [FracBits-1:0] quo_q;
  logic [EST_W:0]      diff_q;
  logic [VAR_W-1:0]    s_q;
  logic [EST_W-1:0]    est_q;
  logic [AccW-1:0]     acc_q;
  logic [ProdW-1:0]    ks_q;
  lane_res_t           res_q;

  logic [EST_W+1:0] trial;
  logic             qbit;
  logic [AccW-1:0]  acc_add;
  logic [ProdW-1:0] ks_add;
  logic [AccW-1:0]  acc_rnd;
  logic [AccW-1:0]  delta;
  logic [ProdW-1:0] var_full;

  assign last_step = (cnt_q == CntW'(FracBits - 1));

  // Restoring divide step: shift remainder, try subtract
  assign trial = {1'b0, rem_q, 1'b0} - {2'b00, den_q};
  assign qbit  = ~trial[EST_W+1];

  // Multiply step, gain bits taken MSB first
  assign acc_add = quo_q[FracBits-1] ? {{(AccW-EST_W-1){diff_q[EST_W]}}, diff_q} : '0;
  assign ks_add  = quo_q[FracBits-1] ? {{(ProdW-VAR_W){1'b0}}, s_q} : '0;

  // Truncate toward zero, then scale back
  assign acc_rnd  = acc_q + (acc_q[AccW-1] ? {{(AccW-FracBits){1'b0}}, {FracBits{1'b1}}} : '0);
  assign delta    = AccW'($signed(acc_rnd) >>> FracBits);
  assign var_full = {s_q, {FracBits{1'b0}}} - ks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == LANE_FIN);
    end
  end

  // Sequence divide, multiply and finish
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      LANE_IDLE: begin
        cnt_d = '0;
        if (start_i) state_d = LANE_DIV;
      end
      LANE_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          cnt_d   = '0;
          state_d = LANE_MUL;
        end
      end
      LANE_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          cnt_d   = '0;
          state_d = LANE_FIN;
        end
      end
      LANE_FIN: state_d = LANE_IDLE;
      default:  state_d = LANE_IDLE;
    endcase
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LANE_IDLE: begin
        if (start_i) begin
          den_q  <= {1'b0, req_i.var_s} + {1'b0, req_i.noise};
          rem_q  <= {1'b0, req_i.var_s};
          quo_q  <= '0;
          diff_q <= {req_i.meas[EST_W-1], req_i.meas} - {req_i.est[EST_W-1], req_i.est};
          s_q    <= req_i.var_s;
          est_q  <= req_i.est;
          acc_q  <= '0;
          ks_q   <= '0;
        end
      end
      LANE_DIV: begin
        if (qbit) rem_q <= trial[EST_W-1:0];
        else      rem_q <= {rem_q[EST_W-2:0], 1'b0};
        quo_q <= {quo_q[FracBits-2:0], qbit};
      end
      LANE_MUL: begin
        acc_q <= {acc_q[AccW-2:0], 1'b0} + acc_add;
        ks_q  <= {ks_q[ProdW-2:0], 1'b0} + ks_add;
        quo_q <= {quo_q[FracBits-2:0], 1'b0};
      end
      LANE_FIN: begin
        res_q.est   <= est_q + delta[EST_W-1:0];
        res_q.var_s <= var_full[ProdW-1:FracBits];
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

### design/diag_kalman_point_update.sv
// Top level: point state, three update lanes, stream and register ports.
//
// Usage: items arrive on the s_axis channel; tuser carries the command
// (0 start/seed, 1 measurement update). Each accepted item produces exactly
// one result on m_axis showing the point state after the item; the result
// tuser carries the error flag (an update with a zero noise value, which
// leaves the state unchanged). The two default variances are set through
// the APB port at byte addresses 0 and 4 and apply at the next start.
// A measurement update runs the bit-serial gain divide and then the
// bit-serial gain multiply, one bit per cycle in each lane; the three lanes
// run side by side. Start and error items go straight to the result and
// skip the lanes. One item is in work at a time; the next is accepted once
// the sequencer is back in idle after the result is loaded. Reset clears
// estimates and depth range to zero, loads the default variances and clears
// the guess mark. When the receiver stalls, the result is held in the output
// register; a following item may be accepted and worked on, and waits for
// the register to free before it is committed.
`default_nettype none
module diag_kalman_point_update import dkpu_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // meas_u[31:0], meas_v[63:32], meas_depth[95:64], noise_u[126:96],
  // noise_v[157:127], noise_depth[188:158], start_guessed[189], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // est_u[31:0], est_v[63:32], est_depth[95:64], var_u[126:96],
  // var_v[157:127], var_depth[188:158], depth_lo[220:189],
  // depth_hi[252:221], is_guessed[253], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // error[0]
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  top_state_e state_q, state_d;

  logic [VAR_W-1:0] def_pix_q, def_dep_q;
  logic [EST_W-1:0] est_q [0:2];
  logic [VAR_W-1:0] var_q [0:2];
  logic [EST_W-1:0] lo_q, hi_q;
  logic             guess_q;

  logic             cmd_q, sg_q, err_q;
  logic [EST_W-1:0] md_q;
  logic [EST_W-1:0] seed_u_q, seed_v_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_err_q;

  logic             in_acc, in_err, commit, out_free;
  logic [2:0]       lane_done;
  lane_req_t        lane_req [0:2];
  lane_res_t        lane_res [0:2];

  logic [EST_W-1:0] est_d [0:2];
  logic [VAR_W-1:0] var_d [0:2];
  logic [EST_W-1:0] lo_d, hi_d;
  logic             guess_d;

  // Input fields
  logic [EST_W-1:0] in_meas  [0:2];
  logic [VAR_W-1:0] in_noise [0:2];

  assign in_meas[0]  = s_axis_tdata[31:0];
  assign in_meas[1]  = s_axis_tdata[63:32];
  assign in_meas[2]  = s_axis_tdata[95:64];
  assign in_noise[0] = s_axis_tdata[126:96];
  assign in_noise[1] = s_axis_tdata[157:127];
  assign in_noise[2] = s_axis_tdata[188:158];

  assign s_axis_tready = (state_q == TOP_IDLE);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign in_err = (s_axis_tuser == CMD_UPDATE) &&
                  ((in_noise[0] == '0) || (in_noise[1] == '0) || (in_noise[2] == '0));
  assign out_free = ~m_valid_q | m_axis_tready;
  assign commit   = (state_q == TOP_FIN) & out_free;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {1'b0, (paddr[2] == REG_DEPTH_VAR) ? def_dep_q : def_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_pix_q <= RESET_PIXEL_VAR;
      def_dep_q <= RESET_DEPTH_VAR;
    end else if (psel & penable & pwrite & pready) begin
      if (paddr[2] == REG_PIXEL_VAR) def_pix_q <= pwdata[VAR_W-1:0];
      else                           def_dep_q <= pwdata[VAR_W-1:0];
    end
  end

  // Component lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign lane_req[g] = '{var_s: var_q[g], noise: in_noise[g],
                           meas: in_meas[g], est: est_q[g]};
    dkpu_lane #(.FracBits(FracBits)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (in_acc & (s_axis_tuser == CMD_UPDATE) & ~in_err),
      .req_i   (lane_req[g]),
      .done_o  (lane_done[g]),
      .res_o   (lane_res[g])
    );
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= TOP_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TOP_IDLE: begin
        if (in_acc) begin
          if ((s_axis_tuser == CMD_UPDATE) && !in_err) state_d = TOP_RUN;
          else                                         state_d = TOP_FIN;
        end
      end
      TOP_RUN: if (&lane_done) state_d = TOP_FIN;
      TOP_FIN: if (out_free) state_d = TOP_IDLE;
      default: state_d = TOP_IDLE;
    endcase
  end

  // Hold the item's control fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser;
      sg_q  <= s_axis_tdata[189];
      err_q <= in_err;
      md_q  <= in_meas[2];
    end
  end

  // Seed u and v held beside the depth
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seed_u_q <= in_meas[0];
      seed_v_q <= in_meas[1];
    end
  end

  // Next point state
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      est_d[i] = est_q[i];
      var_d[i] = var_q[i];
    end
    lo_d    = lo_q;
    hi_d    = hi_q;
    guess_d = guess_q;
    priority if (cmd_q == CMD_START) begin
      est_d[0] = seed_u_q;
      est_d[1] = seed_v_q;
      est_d[2] = md_q;
      var_d[0] = def_pix_q;
      var_d[1] = def_pix_q;
      var_d[2] = def_dep_q;
      lo_d     = md_q;
      hi_d     = md_q;
      guess_d  = sg_q;
    end else if (!err_q) begin
      for (int i = 0; i < 3; i++) begin
        est_d[i] = lane_res[i].est;
        var_d[i] = lane_res[i].var_s;
      end
      if (guess_q) begin
        lo_d    = md_q;
        hi_d    = md_q;
        guess_d = 1'b0;
      end else begin
        if ($signed(md_q) > $signed(hi_q)) hi_d = md_q;
        if ($signed(md_q) < $signed(lo_q)) lo_d = md_q;
      end
    end else begin
      // Zero noise: hold the point state
      guess_d = guess_q;
    end
  end

  // Point state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) est_q[i] <= '0;
      var_q[0] <= RESET_PIXEL_VAR;
      var_q[1] <= RESET_PIXEL_VAR;
      var_q[2] <= RESET_DEPTH_VAR;
      lo_q     <= '0;
      hi_q     <= '0;
      guess_q  <= 1'b0;
    end else if (commit) begin
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= est_d[i];
        var_q[i] <= var_d[i];
      end
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      guess_q <= guess_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= {2'b00, guess_d, hi_d, lo_d, var_d[2], var_d[1], var_d[0],
                   est_d[2], est_d[1], est_d[0]};
      m_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_err_q;

endmodule
`default_nettype wire

### verif/dkpu_checker.sv
// Checker for the point update block: watches both streams, predicts and compares.
`timescale 1ns / 100ps
module dkpu_checker import dkpu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  m_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  input  wire logic                  pready,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct packed {
    logic                   err;
    logic [OUT_DATA_W-1:0]  data;
  } point_state_t;

  // Predicted point state
  logic signed [EST_W-1:0] est_q [3];
  logic [VAR_W-1:0]        var_q [3];
  logic signed [EST_W-1:0] low_q, high_q;
  logic                    guess_q;
  logic [VAR_W-1:0]        pix_default, depth_default;
  point_state_t            expected_states [$];

  assign pending_count = expected_states.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // One scalar gain step on a component
  task automatic update_lane(input int idx, input logic signed [31:0] meas,
                             input logic [VAR_W-1:0] noise);
    logic [63:0]        s, one, k;
    logic signed [63:0] diff, prod, delta;
    s     = 64'(var_q[idx]);
    one   = 64'd1 << FRAC_BITS_DEF;
    k     = (s << FRAC_BITS_DEF) / (s + 64'(noise));
    diff  = 64'(meas) - 64'(est_q[idx]);
    prod  = $signed(k) * diff;
    delta = prod / $signed(one);
    est_q[idx] = EST_W'(64'(est_q[idx]) + delta);
    var_q[idx] = VAR_W'(((one - k) * s) >> FRAC_BITS_DEF);
  endtask

  task automatic predict_point(input logic cmd, input logic [IN_DATA_W-1:0] d);
    logic signed [31:0] mu, mv, md;
    logic [VAR_W-1:0]   nu, nv, nd;
    point_state_t       r;
    mu = d[31:0];   mv = d[63:32];   md = d[95:64];
    nu = d[126:96]; nv = d[157:127]; nd = d[188:158];
    r.err = 1'b0;
    if (cmd == CMD_START) begin
      est_q[0] = mu; est_q[1] = mv; est_q[2] = md;
      var_q[0] = pix_default; var_q[1] = pix_default; var_q[2] = depth_default;
      low_q = md; high_q = md;
      guess_q = d[189];
    end else if (nu == 0 || nv == 0 || nd == 0) begin
      r.err = 1'b1;
    end else begin
      update_lane(0, mu, nu);
      update_lane(1, mv, nv);
      update_lane(2, md, nd);
      if (guess_q) begin
        low_q = md; high_q = md; guess_q = 1'b0;
      end else begin
        if (md > high_q) high_q = md;
        if (md < low_q) low_q = md;
      end
    end
    r.data = {2'b0, guess_q, high_q, low_q, var_q[2], var_q[1], var_q[0],
              est_q[2], est_q[1], est_q[0]};
    expected_states.insert(expected_states.size(), r);
  endtask

  // Track registers and input requests; compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    point_state_t w;
    if (!rst_ni) begin
      est_q = '{default: '0};
      var_q[0] = RESET_PIXEL_VAR; var_q[1] = RESET_PIXEL_VAR;
      var_q[2] = RESET_DEPTH_VAR;
      low_q = '0; high_q = '0; guess_q = 1'b0;
      pix_default = RESET_PIXEL_VAR; depth_default = RESET_DEPTH_VAR;
      expected_states.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PIXEL_VAR) pix_default = pwdata[VAR_W-1:0];
        else depth_default = pwdata[VAR_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          w = expected_states.pop_front();
          if (m_axis_tdata[31:0] !== w.data[31:0])
            report_mismatch("est_u", m_axis_tdata[31:0], w.data[31:0]);
          if (m_axis_tdata[63:32] !== w.data[63:32])
            report_mismatch("est_v", m_axis_tdata[63:32], w.data[63:32]);
          if (m_axis_tdata[95:64] !== w.data[95:64])
            report_mismatch("est_depth", m_axis_tdata[95:64], w.data[95:64]);
          if (m_axis_tdata[126:96] !== w.data[126:96])
            report_mismatch("var_u", m_axis_tdata[126:96], w.data[126:96]);
          if (m_axis_tdata[157:127] !== w.data[157:127])
            report_mismatch("var_v", m_axis_tdata[157:127], w.data[157:127]);
          if (m_axis_tdata[188:158] !== w.data[188:158])
            report_mismatch("var_depth", m_axis_tdata[188:158], w.data[188:158]);
          if (m_axis_tdata[220:189] !== w.data[220:189])
            report_mismatch("depth_lo", m_axis_tdata[220:189], w.data[220:189]);
          if (m_axis_tdata[252:221] !== w.data[252:221])
            report_mismatch("depth_hi", m_axis_tdata[252:221], w.data[252:221]);
          if (m_axis_tdata[253] !== w.data[253])
            report_mismatch("is_guessed", m_axis_tdata[253], w.data[253]);
          if (m_axis_tuser !== w.err)
            report_mismatch("error", m_axis_tuser, w.err);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_point(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

### verif/testbench.sv
// Testbench top: drives points and register writes into the update block.
`timescale 1ns / 100ps
module testbench;
  import dkpu_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int Settle    = 2 * FRAC_BITS_DEF + 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser, m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count, pending_count;
  int                    idle_cycles = 0;
  logic                  sink_hold = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  diag_kalman_point_update DUT (.*);

  dkpu_checker u_checker (.*);

  // Stall the result side: mostly short, sometimes long, sometimes none
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (sink_hold) m_axis_tready <= 1'b1;
    else if (r < 60) m_axis_tready <= 1'b1;
    else if (r < 97) m_axis_tready <= 1'b0;
    else begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(20, 120)) @(posedge clk_i);
    end
  end

  // Watchdog on cycles with no request accepted anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Keep valid high across back-to-back requests; drop it only for a gap
  task automatic send_point(input logic cmd, input logic [31:0] mu, mv, md,
                            input logic [30:0] nu, nv, nd, input logic guessed);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b0, guessed, nd, nv, nu, md, mv, mu};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 8) return 31'h7FFFFFFF;
    if (r < 50) return 31'($urandom_range(1, 1 << 20));
    return 31'($urandom) | 31'd1;
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h80000000;
    if (r == 1) return 32'h7FFFFFFF;
    if (r < 6) return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    return $urandom;
  endfunction

  initial begin
    logic [31:0] d;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults, extremes, zero noise on each lane, guessed flow
    send_point(CMD_UPDATE, 32'h10000, 32'hFFFF0000, 32'h50000, 31'h10000, 31'h10000,
               31'h10000, 1'b0);
    send_point(CMD_START, 32'h7FFFFFFF, 32'h80000000, 32'h00030000, 31'h7FFFFFFF,
               31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1);
    send_point(CMD_UPDATE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'd1, 31'd1,
               31'd1, 1'b1);
    send_point(CMD_UPDATE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
               31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
    send_point(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 31'd0, 31'd5, 31'd5, 1'b0);
    send_point(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 31'd5, 31'd0, 31'd5, 1'b0);
    send_point(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 31'd5, 31'd5, 31'd0, 1'b0);
    drain();
    write_reg(REG_PIXEL_VAR, 32'h7FFFFFFF);
    write_reg(REG_DEPTH_VAR, 32'd1);
    send_point(CMD_START, 32'h0, 32'h0, 32'hFFFF0000, 31'd0, 31'd0, 31'd0, 1'b0);
    send_point(CMD_UPDATE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'd1, 31'd1,
               31'd1, 1'b0);
    send_point(CMD_UPDATE, 32'h100, 32'h100, 32'h80000000, 31'h7FFFFFFF, 31'd1,
               31'h7FFFFFFF, 1'b0);
    drain();
    write_reg(REG_PIXEL_VAR, 32'd0);
    write_reg(REG_DEPTH_VAR, 32'hFFFFFFFF);
    send_point(CMD_START, 32'h12345678, 32'hEDCBA987, 32'h00080000, 31'd3, 31'd3,
               31'd3, 1'b1);
    send_point(CMD_UPDATE, 32'h0, 32'h0, 32'h00020000, 31'd9, 31'd9, 31'd9, 1'b0);
    drain();

    // Random phases, each with its own default variances
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_PIXEL_VAR, (phase == 0) ? 32'd1 : $urandom_range(1, 1 << 22));
      write_reg(REG_DEPTH_VAR, (phase == 1) ? 32'h7FFFFFFF : $urandom);
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          d = rand_coord();
          send_point(CMD_START, rand_coord(), rand_coord(), d, 31'($urandom),
                     31'($urandom), 31'($urandom), 1'($urandom));
        end else begin
          send_point(CMD_UPDATE, rand_coord(), rand_coord(), rand_coord(),
                     rand_noise(), rand_noise(), rand_noise(), 1'($urandom));
        end
        sink_hold <= ($urandom_range(0, 3) == 0);
      end
      drain();
    end

    sink_hold <= 1'b1;
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
design/dkpu_pkg.sv
design/dkpu_lane.sv
design/diag_kalman_point_update.sv
verif/dkpu_checker.sv
verif/testbench.sv
